FILE: rtl/pmf_pkg.sv
// pmf_pkg: shared types and constants for the per-pixel temporal median block
// holds the request structs, the cell control struct and the default sizes
// no dependencies
`default_nettype none

package pmf_pkg;

    // default sizes, handed down through the top level parameters
    localparam int MAX_IMAGES_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 8;

    // fixed field widths of the ports
    localparam int FIELD_W = 8;
    localparam int CFG_W   = 5;

    // image count after reset
    localparam logic [CFG_W-1:0] IMAGE_COUNT_RST = CFG_W'(3);

    // one input request: a sample of the current pixel from the next image
    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } pmf_in_t;

    // one output request: per-channel median of the pixel
    typedef struct packed {
        logic [FIELD_W-1:0] median_red;
        logic [FIELD_W-1:0] median_green;
        logic [FIELD_W-1:0] median_blue;
    } pmf_out_t;

    // control from the top level to one sort cell
    typedef struct packed {
        logic insert;    // a sample is inserted this cycle
        logic occupied;  // the cell holds a sample of the current pixel
    } pmf_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/pmf_cell.sv
// pmf_cell: one slot of a shift-register sorted list for one color channel
// keeps its sample, or takes its left neighbor's, or takes the new sample
// depends on pmf_pkg
`default_nettype none

module pmf_cell #(
    parameter int SAMPLE_BITS = pmf_pkg::SAMPLE_BITS_DEF
) (
    input  wire                         clk,
    input  pmf_pkg::pmf_cell_ctrl_t     ctrl,
    input  wire  [SAMPLE_BITS-1:0]      sample,
    input  wire                         prev_gt,
    input  wire  [SAMPLE_BITS-1:0]      prev_value,
    output logic                        gt,
    output logic [SAMPLE_BITS-1:0]      held_value,
    output logic [SAMPLE_BITS-1:0]      value_next
);
    import pmf_pkg::*;

    logic [SAMPLE_BITS-1:0] value_reg;

    // a held sample larger than the new one moves one place right
    assign gt = ctrl.occupied && (value_reg > sample);

    // held samples not above the new one stay; others take the left value or the new one
    always_comb
    begin
        if (ctrl.occupied && !gt)
        begin
            value_next = value_reg;
        end
        else if (prev_gt)
        begin
            value_next = prev_value;
        end
        else
        begin
            value_next = sample;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            value_reg <= value_next;
        end
    end

    // stored sample handed to the right neighbor
    assign held_value = value_reg;

endmodule

`default_nettype wire

FILE: rtl/per_pixel_median_of_frames.sv
// per_pixel_median_of_frames: temporal median of N aligned RGB images per pixel
// top level: count and config registers, three rows of sort cells, output register
// depends on pmf_pkg and pmf_cell
//
// Usage:
//   pixel channel (pixel_valid, pixel_stall, pixel) carries one RGB sample of the
//   current pixel from each image in turn. After image_count samples (0 acts as 1,
//   values above MAX_IMAGES act as MAX_IMAGES) the block gives one request on the
//   median channel (median_valid, median_stall, median): the entry at sorted
//   index count/2 of each channel, then starts the next pixel.
//   Each sample is inserted into a row of MAX_IMAGES cells per channel at once,
//   so one sample is taken every cycle unless pixel_stall is high. The median
//   request appears in the cycle after the final sample of a pixel is taken.
//   The median is held in an output register; while it waits under median_stall,
//   samples that do not complete a pixel are still taken. Only a sample that
//   would complete the next pixel is stalled until the median is taken.
//   cfg_we writes image_count from cfg_data; write it only while idle.
//   Reset clears the sample count, the output valid and sets image_count to 3;
//   no clearing pass is needed.
`default_nettype none

module per_pixel_median_of_frames #(
    parameter int MAX_IMAGES  = pmf_pkg::MAX_IMAGES_DEF,
    parameter int SAMPLE_BITS = pmf_pkg::SAMPLE_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         pixel_valid,
    output logic                        pixel_stall,
    input  pmf_pkg::pmf_in_t            pixel,
    output logic                        median_valid,
    input  wire                         median_stall,
    output pmf_pkg::pmf_out_t           median,
    input  wire                         cfg_we,
    input  wire  [pmf_pkg::CFG_W-1:0]   cfg_data
);
    import pmf_pkg::*;

    localparam int CW = $clog2(MAX_IMAGES + 1);
    localparam int IW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
    localparam int NCH = 3;
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]   image_count_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               median_valid_reg;
    logic               median_valid_next;
    pmf_out_t           median_reg;
    pmf_out_t           median_next;

    logic [XW-1:0]      cfg_wide;
    logic [CW-1:0]      n_eff;
    logic [CW-1:0]      count_plus;
    logic [IW-1:0]      mid;
    logic               done;
    logic               accept;

    logic [SAMPLE_BITS-1:0] din [NCH];
    logic                   gt [NCH][MAX_IMAGES];
    logic [SAMPLE_BITS-1:0] vheld [NCH][MAX_IMAGES];
    logic [SAMPLE_BITS-1:0] vnext [NCH][MAX_IMAGES];
    pmf_cell_ctrl_t         ctrl [MAX_IMAGES];

    // effective image count, clamped to 1..MAX_IMAGES
    assign cfg_wide = XW'(image_count_reg);
    always_comb
    begin
        priority if (cfg_wide == '0)
        begin
            n_eff = CW'(1);
        end
        else if (cfg_wide > XW'(MAX_IMAGES))
        begin
            n_eff = CW'(MAX_IMAGES);
        end
        else
        begin
            n_eff = CW'(cfg_wide);
        end
    end

    // pixel completes when this sample brings the count to the image count
    assign count_plus  = count_reg + CW'(1);
    assign done        = count_plus >= n_eff;
    assign mid         = IW'(n_eff >> 1);
    assign pixel_stall = median_valid_reg && median_stall && done;
    assign accept      = pixel_valid && !pixel_stall;

    // samples cut to the stored width
    assign din[0] = SAMPLE_BITS'(pixel.red);
    assign din[1] = SAMPLE_BITS'(pixel.green);
    assign din[2] = SAMPLE_BITS'(pixel.blue);

    // rows of sort cells, one row per channel
    for (genvar i = 0; i < MAX_IMAGES; i++)
    begin : g_slot
        assign ctrl[i].insert   = accept;
        assign ctrl[i].occupied = count_reg > CW'(i);
        for (genvar c = 0; c < NCH; c++)
        begin : g_ch
            if (i == 0)
            begin : g_first
                pmf_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[i]),
                    .sample     (din[c]),
                    .prev_gt    (1'b0),
                    .prev_value ({SAMPLE_BITS{1'b0}}),
                    .gt         (gt[c][i]),
                    .held_value (vheld[c][i]),
                    .value_next (vnext[c][i])
                );
            end
            else
            begin : g_rest
                pmf_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[i]),
                    .sample     (din[c]),
                    .prev_gt    (gt[c][i-1]),
                    .prev_value (vheld[c][i-1]),
                    .gt         (gt[c][i]),
                    .held_value (vheld[c][i]),
                    .value_next (vnext[c][i])
                );
            end
        end
    end

    // output register and sample count
    always_comb
    begin
        count_next        = count_reg;
        median_valid_next = median_valid_reg;
        median_next       = median_reg;
        if (median_valid_reg && !median_stall)
        begin
            median_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (done)
            begin
                count_next               = '0;
                median_valid_next        = 1'b1;
                median_next.median_red   = FIELD_W'(vnext[0][mid]);
                median_next.median_green = FIELD_W'(vnext[1][mid]);
                median_next.median_blue  = FIELD_W'(vnext[2][mid]);
            end
            else
            begin
                count_next = count_plus;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_count_reg  <= IMAGE_COUNT_RST;
            count_reg        <= '0;
            median_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                image_count_reg <= cfg_data;
            end
            count_reg        <= count_next;
            median_valid_reg <= median_valid_next;
        end
    end

    // median payload
    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign median_valid = median_valid_reg;
    assign median       = median_reg;

endmodule

`default_nettype wire

FILE: rtl/pmf_checker.sv
// pmf_checker: port-level checks for per_pixel_median_of_frames
// bound to the top level at the end of this file
// depends on pmf_pkg
`default_nettype none

module pmf_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  pixel_valid,
    input wire                  pixel_stall,
    input wire                  median_valid,
    input wire                  median_stall,
    input pmf_pkg::pmf_out_t    median
);
    import pmf_pkg::*;

    // a new median appears only after a sample request was taken
    a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(median_valid) |-> $past(pixel_valid && !pixel_stall))
        else $error("median appeared without a sample request");

    // a taken median is followed by nothing or by one that a new sample made
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        median_valid && !median_stall |=> !median_valid || $past(pixel_valid && !pixel_stall))
        else $error("median repeated");

    // samples stall only while a median waits under stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> median_valid && median_stall)
        else $error("sample stalled with no waiting median");

    // a stalled median holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        median_valid && median_stall |=> median_valid && $stable(median))
        else $error("stalled median changed");

endmodule

bind per_pixel_median_of_frames pmf_checker u_pmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .median_valid (median_valid),
    .median_stall (median_stall),
    .median       (median)
);

`default_nettype wire
